@@ hdl/fir_filter_edge_replicate_top_defines.svh @@
// Assertion macros shared by the RTL of the edge-replicating FIR smoother.
// No dependencies; the bodies become empty when SYNTHESIS is defined.
`ifndef FIR_FILTER_EDGE_REPLICATE_TOP_DEFINES_SVH
`define FIR_FILTER_EDGE_REPLICATE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge out of reset.
`define FER_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked on every rising edge out of reset.
`define FER_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FER_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg)
`define FER_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

@@ hdl/fer_pkg.sv @@
// Shared types and constants of the edge-replicating FIR smoother.
// No dependencies; used by fer_mac and the top level.
package fer_pkg;

  localparam int SAMPLE_W        = 16;
  localparam int COEF_W          = 16;
  localparam int OUT_W           = 18;
  localparam int NUM_COEFS       = 7;
  localparam int CFG_IDX_W       = 3;
  localparam int HALF_W          = 2;
  localparam int FILL_W          = 2;
  localparam int MAX_TAPS_DEF    = 7;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam logic [COEF_W-1:0] COEF0_RST = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic [FILL_W-1:0] FILL_SAT  = {FILL_W{1'b1}};
  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HALF_WIDTH,
    REG_COEF_0,
    REG_COEF_1,
    REG_COEF_2,
    REG_COEF_3,
    REG_COEF_4,
    REG_COEF_5,
    REG_COEF_6
  } cfg_reg_e;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                scan_end;
  } in_beat_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] filtered;
    logic                    final_out;
  } out_beat_t;

  typedef struct packed {
    cfg_reg_e            index;
    logic [COEF_W-1:0]   wdata;
  } cfg_beat_t;

  // Control that travels with one set of aligned taps into the MAC.
  typedef struct packed {
    logic valid;
    logic final_out;
  } job_ctl_t;

  typedef logic [NUM_COEFS-1:0][COEF_W-1:0] coef_vec_t;

endpackage

@@ hdl/fer_chan_if.sv @@
// Valid/ready channel used for the sample, result and configuration ports.
// The payload type is set per instance, normally a struct from fer_pkg.
interface fer_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hdl/fer_mac.sv @@
// Multiply, sum, round and saturate stages of the FIR smoother.
// Depends on fer_pkg and fer_chan_if; drives the result channel directly.
module fer_mac #(
  parameter int MAX_TAPS = fer_pkg::MAX_TAPS_DEF,
  parameter int WIN_W    = fer_pkg::SAMPLE_W
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  fer_pkg::job_ctl_t                 job_i,
  input  logic [MAX_TAPS-1:0][WIN_W-1:0]    taps_i,
  input  fer_pkg::coef_vec_t                coef_i,
  output logic                              job_ready_o,
  fer_chan_if.source                        out_o
);

  localparam int PROD_W    = WIN_W + fer_pkg::COEF_W;
  localparam int RND_SHIFT = fer_pkg::COEF_W - 1;
  localparam int ACC_W     = (PROD_W + 3 > fer_pkg::OUT_W + RND_SHIFT) ?
                             PROD_W + 3 : fer_pkg::OUT_W + RND_SHIFT;
  localparam int RND_W     = ACC_W - RND_SHIFT;
  localparam logic signed [ACC_W-1:0] RND_BIAS = ACC_W'(1) << (RND_SHIFT - 1);
  localparam int OUT_W_HI  = fer_pkg::OUT_W - 1;

  logic signed [PROD_W-1:0] prod_q [MAX_TAPS];
  logic signed [PROD_W-1:0] prod_d [MAX_TAPS];
  logic                     p_valid_q;
  logic                     p_final_q;
  logic                     o_valid_q;
  fer_pkg::out_beat_t       res_q;
  fer_pkg::out_beat_t       res_d;
  logic                     o_load;
  logic                     p_load;
  logic signed [ACC_W-1:0]  acc;
  logic signed [RND_W-1:0]  rnd;
  logic [RND_W-OUT_W_HI-1:0] rnd_hi;

  assign o_load      = !o_valid_q || out_o.ready;
  assign p_load      = !p_valid_q || o_load;
  assign job_ready_o = p_load;

  always_comb begin
    for (int k = 0; k < MAX_TAPS; k++) begin
      prod_d[k] = $signed(PROD_W'($signed(coef_i[k]))) * $signed(PROD_W'(taps_i[k]));
    end
  end

  // Round half up at the Q.15 point, then saturate to the signed 18-bit integer (Q17.0) range.
  always_comb begin
    acc = RND_BIAS;
    for (int k = 0; k < MAX_TAPS; k++) begin
      acc = acc + ACC_W'(prod_q[k]);
    end
    rnd    = acc[ACC_W-1:RND_SHIFT];
    rnd_hi = rnd[RND_W-1:OUT_W_HI];
    res_d.final_out = p_final_q;
    if ((&rnd_hi) || !(|rnd_hi)) begin
      res_d.filtered = rnd[fer_pkg::OUT_W-1:0];
    end else if (rnd[RND_W-1]) begin
      res_d.filtered = fer_pkg::OUT_MIN;
    end else begin
      res_d.filtered = fer_pkg::OUT_MAX;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (p_load) begin
        p_valid_q <= job_i.valid;
      end
      if (o_load) begin
        o_valid_q <= p_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_load) begin
      prod_q    <= prod_d;
      p_final_q <= job_i.final_out;
    end
    if (o_load) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid = o_valid_q;
  assign out_o.data  = res_q;

endmodule

@@ hdl/fir_filter_edge_replicate_top.sv @@
// Top level of the edge-replicating FIR smoother for range scans.
// Depends on fer_pkg, fer_chan_if, fer_mac and the assertion macro header.
//
//   port    direction  payload                         beat taken when
//   cfg_i   in         index (cfg_reg_e), wdata[15:0]  valid and ready (ready is always high)
//   in_i    in         sample[15:0], scan_end          valid and ready
//   out_o   out        filtered[17:0] signed, final_out valid and ready
//
// One sample beat is taken per cycle unless stalled or draining; a scan_end
// beat with h nonzero holds the input off while the last sample shifts through the window.
// A result passes through the job, product and output registers in turn before it leaves.
// Reset is immediate: there is no clearing pass, the first sample of a scan fills
// the window. Backpressure on out_o stalls the output, product and job registers.
`include "fir_filter_edge_replicate_top_defines.svh"

module fir_filter_edge_replicate_top #(
  parameter int MAX_TAPS    = fer_pkg::MAX_TAPS_DEF,
  parameter int SAMPLE_BITS = fer_pkg::SAMPLE_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  fer_chan_if.sink    cfg_i,
  fer_chan_if.sink    in_i,
  fer_chan_if.source  out_o
);

  localparam int WIN_W = (SAMPLE_BITS < fer_pkg::SAMPLE_W) ? SAMPLE_BITS : fer_pkg::SAMPLE_W;
  localparam int HMAX  = (MAX_TAPS - 1) / 2;

  // Configuration registers.
  logic [fer_pkg::HALF_W-1:0]    half_q;
  fer_pkg::coef_vec_t            coef_q;
  logic [fer_pkg::CFG_IDX_W-1:0] coef_sel;
  logic [fer_pkg::HALF_W-1:0]    h_eff;

  // Scan tracking and drain sequencing.
  logic [fer_pkg::FILL_W-1:0] fill_q, fill_d;
  logic [fer_pkg::FILL_W-1:0] dfill_q, dfill_d;
  logic [fer_pkg::HALF_W-1:0] step_q, step_d;
  logic                       in_scan_q, in_scan_d;
  logic                       drain_q, drain_d;

  logic [MAX_TAPS-1:0][WIN_W-1:0] win_q, win_d;
  logic [MAX_TAPS-1:0][WIN_W-1:0] job_taps_q, job_taps_d;
  fer_pkg::job_ctl_t              job_q, job_d;
  logic                           job_ready;
  logic                           j_load;
  logic                           in_acc;
  logic                           do_fill;
  logic                           do_shift;
  logic [WIN_W-1:0]               s;
  logic [WIN_W-1:0]               shift_in;
  logic [fer_pkg::FILL_W-1:0]     f;
  logic                           emit;
  logic                           fin;

  assign cfg_i.ready = 1'b1;
  assign coef_sel    = cfg_i.data.index - fer_pkg::CFG_IDX_W'(1);
  assign h_eff       = (int'(half_q) > HMAX) ? fer_pkg::HALF_W'(HMAX) : half_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q <= '0;
      coef_q <= '{0: fer_pkg::COEF0_RST, default: '0};
    end else if (cfg_i.valid) begin
      unique case (cfg_i.data.index)
        fer_pkg::REG_HALF_WIDTH: half_q <= cfg_i.data.wdata[fer_pkg::HALF_W-1:0];
        default:                 coef_q[coef_sel] <= cfg_i.data.wdata;
      endcase
    end
  end

  assign j_load     = !job_q.valid || job_ready;
  assign in_i.ready = j_load && !drain_q;
  assign in_acc     = in_i.valid && in_i.ready;
  assign s          = in_i.data.sample[WIN_W-1:0];

  always_comb begin
    fill_d    = fill_q;
    dfill_d   = dfill_q;
    step_d    = step_q;
    in_scan_d = in_scan_q;
    drain_d   = drain_q;
    do_fill   = 1'b0;
    do_shift  = 1'b0;
    shift_in  = s;
    f         = fill_q;
    emit      = 1'b0;
    fin       = 1'b0;

    if (drain_q) begin
      // After the last sample, it is shifted in again once per step.
      if (j_load) begin
        do_shift = 1'b1;
        shift_in = win_q[MAX_TAPS-1];
        emit     = (3'(dfill_q) + 3'(step_q)) >= 3'(h_eff);
        fin      = (step_q == h_eff);
        if (fin) begin
          drain_d = 1'b0;
        end else begin
          step_d = step_q + fer_pkg::HALF_W'(1);
        end
      end
    end else if (in_acc) begin
      if (!in_scan_q) begin
        do_fill = 1'b1;
        f       = '0;
      end else begin
        do_shift = 1'b1;
      end
      emit = (f >= h_eff);
      fin  = in_i.data.scan_end && (h_eff == '0);
      if (in_i.data.scan_end) begin
        in_scan_d = 1'b0;
        fill_d    = '0;
        if (h_eff != '0) begin
          drain_d = 1'b1;
          step_d  = fer_pkg::HALF_W'(1);
          dfill_d = f;
        end
      end else begin
        in_scan_d = 1'b1;
        fill_d    = (f == fer_pkg::FILL_SAT) ? f : f + fer_pkg::FILL_W'(1);
      end
    end
  end

  always_comb begin
    win_d = win_q;
    if (do_fill) begin
      for (int i = 0; i < MAX_TAPS; i++) begin
        win_d[i] = s;
      end
    end else if (do_shift) begin
      for (int i = 0; i < MAX_TAPS - 1; i++) begin
        win_d[i] = win_q[i+1];
      end
      win_d[MAX_TAPS-1] = shift_in;
    end
  end

  // Align the newest 2h+1 samples with coefficients 0..2h; unused taps read zero.
  always_comb begin
    job_d      = job_q;
    job_taps_d = job_taps_q;
    if (j_load) begin
      job_d.valid     = emit;
      job_d.final_out = fin;
      for (int k = 0; k < MAX_TAPS; k++) begin
        job_taps_d[k] = '0;
        for (int hh = 0; hh <= HMAX; hh++) begin
          if (h_eff == fer_pkg::HALF_W'(hh) && k <= 2 * hh) begin
            job_taps_d[k] = win_d[MAX_TAPS-1-2*hh+k];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q    <= '0;
      dfill_q   <= '0;
      step_q    <= '0;
      in_scan_q <= 1'b0;
      drain_q   <= 1'b0;
      job_q     <= '0;
    end else begin
      fill_q    <= fill_d;
      dfill_q   <= dfill_d;
      step_q    <= step_d;
      in_scan_q <= in_scan_d;
      drain_q   <= drain_d;
      job_q     <= job_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q      <= win_d;
    job_taps_q <= job_taps_d;
  end

  fer_mac #(
    .MAX_TAPS (MAX_TAPS),
    .WIN_W    (WIN_W)
  ) u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job_q),
    .taps_i      (job_taps_q),
    .coef_i      (coef_q),
    .job_ready_o (job_ready),
    .out_o       (out_o)
  );

  `FER_ASSERT_NOW(a_drain_blocks_input, clk_i, rst_ni, drain_q, !in_i.ready, "input taken during drain")
  `FER_ASSERT_NOW(a_step_range, clk_i, rst_ni, drain_q, (step_q != '0) && (step_q <= h_eff), "drain step out of range")
  `FER_ASSERT_NEXT(a_job_held, clk_i, rst_ni, job_q.valid && !job_ready, job_q.valid && $stable(job_q.final_out), "stalled job lost")
  `FER_ASSERT_NEXT(a_scan_closes, clk_i, rst_ni, in_acc && in_i.data.scan_end, !in_scan_q && (fill_q == '0), "scan not closed at end")

endmodule
